// ----- design/jesc_pkg.sv -----
package jesc_pkg;

  // Most bytes one input word can produce (replacement char plus an escape pair).
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  // Result of one decode step: bytes in order from index 0, count valid.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
  } jesc_res_t;

endpackage

// ----- design/jesc_step.sv -----
module jesc_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,    // take the word below this cycle
  input  logic [7:0]        byte_i,
  input  logic              end_i,
  output jesc_pkg::jesc_res_t res_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhEsc,
    PhHex1,
    PhWantBs,
    PhWantU,
    PhHex2
  } phase_e;

  // Short byte run: up to four bytes, b[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } seg_t;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChU         = 8'h75;
  localparam seg_t       SegNone     = '{b: '0, len: 3'd0};
  localparam seg_t       SegRepl     = '{b: {8'h00, 8'hBD, 8'hBF, 8'hEF}, len: 3'd3};

  phase_e      phase_q, phase_d;
  logic [11:0] acc_q, acc_d;   // at most three digits held between words
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hs_q, hs_d;

  logic        is_dig, is_bs, full, fin_lo, fin_hi;
  logic [3:0]  dig;
  logic [15:0] fin_v;
  logic [20:0] cp;
  seg_t        seg_a, seg_b, first_seg, second_seg;

  function automatic seg_t one_byte(input logic [7:0] v);
    seg_t s;
    s      = SegNone;
    s.b[0] = v;
    s.len  = 3'd1;
    return s;
  endfunction

  function automatic seg_t esc_seg(input logic [7:0] v);
    seg_t s;
    s = SegNone;
    case (v)
      8'h22:       s = one_byte(8'h22);
      ChBackslash: s = one_byte(ChBackslash);
      8'h2F:       s = one_byte(8'h2F);
      8'h62:       s = one_byte(8'h08);
      8'h66:       s = one_byte(8'h0C);
      8'h6E:       s = one_byte(8'h0A);
      8'h72:       s = one_byte(8'h0D);
      8'h74:       s = one_byte(8'h09);
      default: begin
        s.b[0] = ChBackslash;
        s.b[1] = v;
        s.len  = 3'd2;
      end
    endcase
    return s;
  endfunction

  function automatic seg_t utf8_bmp(input logic [15:0] v);
    seg_t s;
    s = SegNone;
    if (v == 16'h0000) begin
      s = SegNone;
    end else if (v < 16'h0080) begin
      s = one_byte(v[7:0]);
    end else if (v < 16'h0800) begin
      s.b[0] = {3'b110, v[10:6]};
      s.b[1] = {2'b10, v[5:0]};
      s.len  = 3'd2;
    end else begin
      s.b[0] = {4'b1110, v[15:12]};
      s.b[1] = {2'b10, v[11:6]};
      s.b[2] = {2'b10, v[5:0]};
      s.len  = 3'd3;
    end
    return s;
  endfunction

  // Hex digit decode, lowercase only.
  always_comb begin
    is_dig = 1'b0;
    dig    = byte_i[3:0];
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      is_dig = 1'b1;
    end else if (byte_i >= 8'h61 && byte_i <= 8'h66) begin
      is_dig = 1'b1;
      dig    = byte_i[3:0] + 4'd9;
    end
  end

  assign is_bs  = (byte_i == ChBackslash);
  assign full   = is_dig && (cnt_q == 2'd3) && !end_i;
  assign fin_v  = full ? {acc_q, dig} : {4'h0, acc_q};
  assign fin_lo = (fin_v[15:10] == 6'b110111);
  assign fin_hi = (fin_v[15:10] == 6'b110110);
  assign cp     = {1'b0, hs_q, fin_v[9:0]} + 21'h10000;

  always_comb begin
    first_seg = fin_lo ? SegRepl : utf8_bmp(fin_v);
    if (fin_lo) begin
      second_seg.b[0] = {5'b11110, cp[20:18]};
      second_seg.b[1] = {2'b10, cp[17:12]};
      second_seg.b[2] = {2'b10, cp[11:6]};
      second_seg.b[3] = {2'b10, cp[5:0]};
      second_seg.len  = 3'd4;
    end else begin
      second_seg = SegRepl;
    end
  end

  always_comb begin
    seg_a   = SegNone;
    seg_b   = SegNone;
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    hs_d    = hs_q;
    if (end_i) begin
      case (phase_q)
        PhEsc:    seg_b = one_byte(ChBackslash);
        PhHex1:   seg_a = fin_hi ? SegRepl : first_seg;
        PhHex2:   seg_a = second_seg;
        PhWantBs: seg_a = SegRepl;
        PhWantU: begin
          seg_a = SegRepl;
          seg_b = one_byte(ChBackslash);
        end
        default: ;
      endcase
      phase_d = PhIdle;
      acc_d   = '0;
      cnt_d   = '0;
      hs_d    = '0;
    end else begin
      case (phase_q)
        PhEsc: begin
          phase_d = PhIdle;
          if (byte_i == ChU) begin
            phase_d = PhHex1;
            acc_d   = '0;
            cnt_d   = '0;
          end else begin
            seg_b = esc_seg(byte_i);
          end
        end
        PhHex1, PhHex2: begin
          if (is_dig && !full) begin
            acc_d = {acc_q[7:0], dig};
            cnt_d = cnt_q + 2'd1;
          end else begin
            // run complete: fourth digit or a terminating byte
            acc_d = '0;
            cnt_d = '0;
            if (phase_q == PhHex1) begin
              if (fin_hi) begin
                hs_d    = fin_v[9:0];
                phase_d = PhWantBs;
              end else begin
                seg_a   = first_seg;
                phase_d = PhIdle;
              end
            end else begin
              seg_a   = second_seg;
              hs_d    = '0;
              phase_d = PhIdle;
            end
            // terminating byte is decoded again in the new phase
            if (!is_dig) begin
              if (phase_q == PhHex1 && fin_hi) begin
                if (is_bs) begin
                  phase_d = PhWantU;
                end else begin
                  seg_a   = SegRepl;
                  seg_b   = one_byte(byte_i);
                  hs_d    = '0;
                  phase_d = PhIdle;
                end
              end else if (is_bs) begin
                phase_d = PhEsc;
              end else begin
                seg_b = one_byte(byte_i);
              end
            end
          end
        end
        PhWantBs: begin
          if (is_bs) begin
            phase_d = PhWantU;
          end else begin
            seg_a   = SegRepl;
            seg_b   = one_byte(byte_i);
            hs_d    = '0;
            phase_d = PhIdle;
          end
        end
        PhWantU: begin
          if (byte_i == ChU) begin
            acc_d   = '0;
            cnt_d   = '0;
            phase_d = PhHex2;
          end else begin
            // lone high surrogate, then treat the byte as a fresh escape
            seg_a   = SegRepl;
            seg_b   = esc_seg(byte_i);
            hs_d    = '0;
            phase_d = PhIdle;
          end
        end
        default: begin
          if (is_bs) begin
            phase_d = PhEsc;
          end else begin
            seg_b   = one_byte(byte_i);
            phase_d = PhIdle;
          end
        end
      endcase
    end
  end

  // Join the two runs into the result word.
  always_comb begin
    logic [2:0] k;
    logic [2:0] j;
    res_o.count = seg_a.len + seg_b.len;
    for (int i = 0; i < jesc_pkg::MaxResults; i++) begin
      k = 3'(i);
      j = k - seg_a.len;
      if (k < seg_a.len) begin
        res_o.bytes[i] = seg_a.b[k[1:0]];
      end else begin
        res_o.bytes[i] = seg_b.b[j[1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      cnt_q   <= '0;
      hs_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hs_q    <= hs_d;
    end
  end

endmodule

// ----- design/json_escape_to_utf8_decoder_core.sv -----
// JSON string-body escape decoder, bytes in, UTF-8 bytes out.
//
// Slave stream: one raw string byte per word on tdata; tlast marks end of
// input, which flushes any pending escape (tdata is ignored on that word).
// Master stream: one decoded byte per word; tlast is set on the last byte
// produced by a given input word. A word that produces nothing (a backslash,
// a hex digit, end of input with nothing pending) gives no output word.
//
// A word is held in the input register, then decoded and loaded into the
// result buffer once that is free; its first byte goes out from that buffer.
// Throughput: one input word per cycle while each yields at most one byte and
// the receiver is ready; a word yielding more bytes (up to five) holds the
// input while the result buffer drains, one byte per cycle while the receiver
// is ready, and is taken as the buffer hands over its last byte.
//
// Reset clears the escape state to idle and empties both registers.
// When the receiver stalls, the result buffer holds, the input register
// fills, and s_axis_tready_o drops until the buffer can be reloaded.
module json_escape_to_utf8_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // end_of_input
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // last_of_run
);

  // Input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Result buffer: bytes shift down as they go out, rem_q counts what is left
  logic [jesc_pkg::MaxResults-1:0][7:0] buf_q, buf_d;
  logic [jesc_pkg::CountW-1:0]          rem_q, rem_d;

  jesc_pkg::jesc_res_t step_res;
  logic                step_en;
  logic                buf_free;
  logic                pop;

  assign pop      = m_axis_tvalid_o && m_axis_tready_i;
  // buffer can take a new result if empty or handing over its last byte now
  assign buf_free = (rem_q == '0) || ((rem_q == jesc_pkg::CountW'(1)) && m_axis_tready_i);
  assign step_en  = in_vld_q && buf_free;

  assign s_axis_tready_o = !in_vld_q || step_en;

  jesc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step_en),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    if (step_en) begin
      buf_d = step_res.bytes;
      rem_d = step_res.count;
    end else if (pop) begin
      buf_d = buf_q >> 8;
      rem_d = rem_q - jesc_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tdata_o  = buf_q[0];
  assign m_axis_tlast_o  = (rem_q == jesc_pkg::CountW'(1));

  // The buffer never holds more bytes than one word can produce.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= jesc_pkg::CountW'(jesc_pkg::MaxResults))
    else $error("result buffer count out of range");

  // A decode step never overwrites bytes still waiting to go out.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q > jesc_pkg::CountW'(1)) |-> !step_en)
    else $error("decode step while result buffer busy");

  // A held input word keeps its contents until decoded.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step_en) |=> (in_vld_q && $stable(in_byte_q) && $stable(in_end_q)))
    else $error("input register changed while waiting");

  // Each decoded word yields no more bytes than the buffer depth.
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |-> (step_res.count <= jesc_pkg::CountW'(jesc_pkg::MaxResults)))
    else $error("decode step produced too many bytes");

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords = 420;
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 20;

  // Characters the decoder reacts to
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowU      = 8'h75;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChLowX      = 8'h78;
  // Control bytes for the simple escapes
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlCr  = 8'h0D;
  // U+FFFD in UTF-8
  localparam logic [7:0] Repl0 = 8'hEF;
  localparam logic [7:0] Repl1 = 8'hBF;
  localparam logic [7:0] Repl2 = 8'hBD;
  // Surrogate ranges
  localparam logic [15:0] HighSurLo = 16'hD800;
  localparam logic [15:0] HighSurHi = 16'hDBFF;
  localparam logic [15:0] LowSurLo  = 16'hDC00;
  localparam logic [15:0] LowSurHi  = 16'hDFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESC,
    ST_HEX_FIRST,
    ST_WANT_BSL,
    ST_WANT_U,
    ST_HEX_SECOND
  } esc_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;   // end of input
  } in_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;   // last byte of this input word
  } out_word_t;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  in_word_t   raw_q[$];       // words still to send
  out_word_t  decoded_q[$];   // bytes still expected from the block
  int unsigned n_total;
  int unsigned n_accepted = 0;
  int unsigned err_count = 0;

  // Predictor state
  esc_state_e  esc_state = ST_IDLE;
  logic [15:0] hex_acc = '0;
  logic [2:0]  hex_cnt = '0;
  logic [9:0]  high_sur = '0;
  logic [7:0]  step_bytes[$];

  json_escape_to_utf8_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b);
    step_bytes.push_back(b);
  endfunction

  function automatic void put_repl();
    put_byte(Repl0);
    put_byte(Repl1);
    put_byte(Repl2);
  endfunction

  function automatic void put_utf8(logic [20:0] cp);
    if (cp == '0) begin
      return;   // code point zero gives nothing
    end
    if (cp < 21'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic int nibble_of(logic [7:0] b);
    if (b >= ChZero && b <= ChNine) begin
      return int'(b - ChZero);
    end
    if (b >= ChLowA && b <= ChLowF) begin
      return int'(b - ChLowA) + 10;
    end
    return -1;
  endfunction

  function automatic void clear_hex();
    hex_acc = '0;
    hex_cnt = '0;
  endfunction

  function automatic void close_first_run();
    logic [15:0] v;
    v = hex_acc;
    clear_hex();
    if (v >= LowSurLo && v <= LowSurHi) begin
      put_repl();           // lone low surrogate
      esc_state = ST_IDLE;
    end else if (v >= HighSurLo && v <= HighSurHi) begin
      high_sur  = v[9:0];
      esc_state = ST_WANT_BSL;
    end else begin
      put_utf8({5'b0, v});
      esc_state = ST_IDLE;
    end
  endfunction

  function automatic void close_second_run();
    logic [15:0] v;
    v = hex_acc;
    clear_hex();
    if (v < LowSurLo || v > LowSurHi) begin
      put_repl();
    end else begin
      put_utf8(21'h10000 + {1'b0, high_sur, v[9:0]});
    end
    high_sur  = '0;
    esc_state = ST_IDLE;
  endfunction

  // Returns 1 once the byte is used up, 0 if it has to go round again
  function automatic bit consume_byte(logic [7:0] b);
    int d;
    case (esc_state)
      ST_ESC: begin
        esc_state = ST_IDLE;
        case (b)
          ChQuote:     put_byte(ChQuote);
          ChBackslash: put_byte(ChBackslash);
          ChSlash:     put_byte(ChSlash);
          ChLowB:      put_byte(CtlBs);
          ChLowF:      put_byte(CtlFf);
          ChLowN:      put_byte(CtlLf);
          ChLowR:      put_byte(CtlCr);
          ChLowT:      put_byte(CtlTab);
          ChLowU: begin
            clear_hex();
            esc_state = ST_HEX_FIRST;
          end
          default: begin
            put_byte(ChBackslash);
            put_byte(b);
          end
        endcase
        return 1'b1;
      end
      ST_HEX_FIRST, ST_HEX_SECOND: begin
        d = nibble_of(b);
        if (d < 0) begin
          if (esc_state == ST_HEX_FIRST) close_first_run();
          else close_second_run();
          return 1'b0;
        end
        hex_acc = {hex_acc[11:0], d[3:0]};
        hex_cnt = hex_cnt + 3'd1;
        if (hex_cnt >= 3'd4) begin
          if (esc_state == ST_HEX_FIRST) close_first_run();
          else close_second_run();
        end
        return 1'b1;
      end
      ST_WANT_BSL: begin
        if (b == ChBackslash) begin
          esc_state = ST_WANT_U;
          return 1'b1;
        end
        put_repl();
        high_sur  = '0;
        esc_state = ST_IDLE;
        return 1'b0;
      end
      ST_WANT_U: begin
        if (b == ChLowU) begin
          clear_hex();
          esc_state = ST_HEX_SECOND;
          return 1'b1;
        end
        put_repl();
        high_sur  = '0;
        esc_state = ST_ESC;   // byte taken as if after a fresh backslash
        return 1'b0;
      end
      default: begin
        esc_state = ST_IDLE;
        if (b == ChBackslash) esc_state = ST_ESC;
        else put_byte(b);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void flush_pending();
    case (esc_state)
      ST_ESC: put_byte(ChBackslash);
      ST_HEX_FIRST: begin
        close_first_run();
        if (esc_state == ST_WANT_BSL) put_repl();
      end
      ST_HEX_SECOND: close_second_run();
      ST_WANT_BSL: put_repl();
      ST_WANT_U: begin
        put_repl();
        put_byte(ChBackslash);
      end
      default: ;
    endcase
    esc_state = ST_IDLE;
    clear_hex();
    high_sur = '0;
  endfunction

  // Works out the bytes one accepted input word gives and queues them
  function automatic void decode_word(in_word_t w);
    int unsigned n;
    step_bytes.delete();
    if (w.last) begin
      flush_pending();
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (consume_byte(w.data)) break;
      end
    end
    n = step_bytes.size();
    if (n > jesc_pkg::MaxResults) n = jesc_pkg::MaxResults;
    for (int unsigned i = 0; i < n; i++) begin
      decoded_q.push_back('{data: step_bytes[i], last: (i == n - 1)});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_raw(logic [7:0] b);
    raw_q.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void push_end();
    raw_q.push_back('{data: 8'($urandom_range(255)), last: 1'b1});
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? ChZero + 8'(n) : ChLowA + 8'(n - 4'd10);
  endfunction

  // backslash-u and four lowercase digits
  function automatic void push_u4(logic [15:0] v);
    push_raw(ChBackslash);
    push_raw(ChLowU);
    for (int i = 3; i >= 0; i--) push_raw(hex_char(v[i*4 +: 4]));
  endfunction

  // backslash-u and fewer than four digits, left open
  function automatic void push_u_short(int unsigned k);
    push_raw(ChBackslash);
    push_raw(ChLowU);
    for (int unsigned i = 0; i < k; i++) push_raw(hex_char(4'($urandom_range(15))));
  endfunction

  // Something that stops a hex run early, or a random byte that may not
  function automatic void push_run_breaker();
    case ($urandom_range(4))
      0: push_raw(ChUpA + 8'($urandom_range(5)));
      1: push_raw(ChBackslash);
      2: push_raw(ChLowX);
      3: push_end();
      default: push_raw(8'($urandom_range(255)));
    endcase
  endfunction

  function automatic logic [15:0] rand_code_point();
    case ($urandom_range(5))
      0: return 16'($urandom_range(16'h7F));
      1: return 16'h80 + 16'($urandom_range(16'h77F));
      2: return 16'h800 + 16'($urandom_range(16'hD7FF - 16'h800));
      3: return 16'hE000 + 16'($urandom_range(16'h1FFF));
      4: return 16'h0000;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_high_sur();
    return HighSurLo + 16'($urandom_range(16'h3FF));
  endfunction

  function automatic logic [15:0] rand_low_sur();
    return LowSurLo + 16'($urandom_range(16'h3FF));
  endfunction

  function automatic logic [7:0] rand_simple_esc();
    case ($urandom_range(7))
      0: return ChQuote;
      1: return ChBackslash;
      2: return ChSlash;
      3: return ChLowB;
      4: return ChLowF;
      5: return ChLowN;
      6: return ChLowR;
      default: return ChLowT;
    endcase
  endfunction

  // Idle rates move with progress: receiver-heavy, sender-heavy, then none
  function automatic int unsigned stage_of();
    if (n_accepted * 3 < n_total) return 0;
    if (n_accepted * 3 < n_total * 2) return 1;
    return 2;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: slave side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    int unsigned idle_pct;
    in_word_t    nxt;
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        decode_word('{data: s_tdata, last: s_tlast});
        n_accepted++;
      end
      case (stage_of())
        0: idle_pct = 22;
        1: idle_pct = 45;
        default: idle_pct = 0;
      endcase
      // load a new word only when the current one has gone or none is up
      if (!s_tvalid || s_tready) begin
        if (raw_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = raw_q.pop_front();
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stalls and monitor: master side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    int unsigned idle_pct;
    case (stage_of())
      0: idle_pct = 45;
      1: idle_pct = 22;
      default: idle_pct = 0;
    endcase
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_n && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word data=%02h last=%0b", $time, m_tdata, m_tlast);
      end else begin
        exp_w = decoded_q.pop_front();
        if (m_tdata !== exp_w.data) begin
          err_count++;
          $display("%0t: out_byte expected %02h actual %02h", $time, exp_w.data, m_tdata);
        end
        if (m_tlast !== exp_w.last) begin
          err_count++;
          $display("%0t: last_of_run expected %0b actual %0b", $time, exp_w.last, m_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n_directed;
    int unsigned r;

    // directed: byte extremes
    push_raw(8'h00);
    push_raw(8'hFF);
    // unknown escape of byte zero
    push_raw(ChBackslash);
    push_raw(8'h00);
    push_raw(ChBackslash);
    push_raw(ChQuote);
    // uppercase ends an empty run: code point zero, then the byte afresh
    push_raw(ChBackslash);
    push_raw(ChLowU);
    push_raw(ChUpA);
    // lone low surrogate
    push_u4(LowSurLo);
    // high surrogate then a plain byte
    push_u4(HighSurLo);
    push_raw(ChLowX);
    // end of input after a lone backslash, then within a hex run
    push_raw(ChBackslash);
    push_end();
    push_u_short(1);
    push_end();
    n_directed = raw_q.size();

    while (raw_q.size() < n_directed + RandomWords) begin
      r = $urandom_range(99);
      if (r < 20) begin
        push_raw(8'($urandom_range(255)));
      end else if (r < 34) begin
        push_raw(ChBackslash);
        push_raw(rand_simple_esc());
      end else if (r < 40) begin
        push_raw(ChBackslash);
        push_raw(8'($urandom_range(255)));
      end else if (r < 58) begin
        push_u4(rand_code_point());
      end else if (r < 67) begin
        push_u_short($urandom_range(3));
        push_run_breaker();
      end else if (r < 80) begin
        push_u4(rand_high_sur());
        push_u4(rand_low_sur());
      end else if (r < 93) begin
        // broken pairs
        push_u4(rand_high_sur());
        case ($urandom_range(5))
          0: push_raw(8'($urandom_range(255)));
          1: begin
            push_raw(ChBackslash);
            push_raw(8'($urandom_range(255)));
          end
          2: push_u4(rand_code_point());
          3: push_end();
          4: begin
            push_raw(ChBackslash);
            push_end();
          end
          default: begin
            push_u_short($urandom_range(3));
            push_run_breaker();
          end
        endcase
      end else begin
        if ($urandom_range(1)) push_raw(ChBackslash);
        push_end();
      end
    end
    n_total = raw_q.size();

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    while (n_accepted != n_total) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("%0t: timeout", $time);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- json_escape_to_utf8_decoder_core.f -----
design/jesc_pkg.sv
design/jesc_step.sv
design/json_escape_to_utf8_decoder_core.sv
verif/testbench.sv
